[src/srcap_pkg.sv]
// Shared types and constants for the step-response capture block.
package srcap_pkg;

    // Capture store size and derived widths
    localparam int CAPTURE_DEPTH = 1024;
    localparam int ADDR_W        = $clog2(CAPTURE_DEPTH);
    localparam int COUNT_W       = $clog2(CAPTURE_DEPTH + 1);

    // Fixed sequence offsets
    localparam logic [31:0] STEP_OFFSET   = 32'd99;
    localparam logic [32:0] END_OFFSET    = 33'd1000;
    localparam logic [30:0] SETTLE_RESET  = 31'd10000;
    localparam logic [15:0] DIVIDER_RESET = 16'd1;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_DIVIDER = 2'd0,
        REG_SETTLE  = 2'd1,
        REG_START   = 2'd2,
        REG_STEP    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        op_t                operation;
        logic signed [15:0] sample_first;
        logic signed [15:0] sample_second;
        logic               start_request;
        logic               clear_request;
        logic [9:0]         read_index;
    } cmd_item_t;

    typedef struct packed {
        logic                ref_write;
        logic signed [31:0]  ref_value;
        logic                recording;
        logic                sequence_active;
        logic [COUNT_W-1:0]  captured_count;
        logic signed [15:0]  read_first;
        logic signed [15:0]  read_second;
    } rsp_item_t;

    // Write request into the capture store
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } store_wr_t;

endpackage

[src/srcap_store.sv]
// Capture store: one write port, one registered read port.
module srcap_store (
    input  logic                      clk,
    input  srcap_pkg::store_wr_t      wr,
    input  logic                      rd_en,
    input  logic [srcap_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]               rd_data
);
    import srcap_pkg::*;

    logic [31:0] mem [CAPTURE_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/step_response_capture.sv]
// Top level of the step-response test sequencer with two-channel capture.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd_item): one item per handshake,
//   either a tick carrying two samples or a read of one stored sample pair.
//   start_request and clear_request on any item set their flags first.
//   rsp channel (rsp_valid / rsp_stall / rsp_item): exactly one item back
//   for every accepted command, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while the block is idle.
// Timing and throughput: a response appears in the cycle after its command
//   is accepted (the capture store read is registered alongside it). One command per
//   cycle is taken, limited only by the single response register.
// Stall: while the response register is full and rsp_stall is high, the
//   response holds and cmd_stall is raised in the same cycle.
// Reset: all sequencer state and registers return to their defaults
//   (divider 1, settle 10000, both references 0). The capture store is not
//   cleared; entries are only meaningful below captured_count.
module step_response_capture (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  srcap_pkg::cmd_item_t      cmd_item,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output srcap_pkg::rsp_item_t      rsp_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  srcap_pkg::cfg_reg_t       cfg_index,
    input  logic [31:0]               cfg_data
);
    import srcap_pkg::*;

    // Configuration registers; the event counts are precomputed on write
    logic [15:0]        divider_reg;
    logic [31:0]        settle_count_reg;   // settle, zero extended
    logic [31:0]        step_count_reg;     // settle + 99
    logic [32:0]        end_count_reg;      // 2*settle + 1000
    logic signed [31:0] start_ref_reg;
    logic signed [31:0] step_ref_reg;

    // Sequencer state
    logic [15:0]        prescale_reg;
    logic [15:0]        prescale_next;
    logic [31:0]        seq_count_reg;
    logic [31:0]        seq_count_next;
    logic               run_reg;
    logic               run_next;
    logic               clear_reg;
    logic               clear_next;
    logic               capture_reg;
    logic               capture_next;
    logic [COUNT_W-1:0] wpos_reg;
    logic [COUNT_W-1:0] wpos_next;

    // Response register (store read data is registered alongside it)
    logic               rsp_valid_reg;
    logic               rsp_ref_write_reg;
    logic signed [31:0] rsp_ref_value_reg;
    logic               rsp_recording_reg;
    logic               rsp_active_reg;
    logic [COUNT_W-1:0] rsp_count_reg;
    logic               rsp_read_reg;

    // Per-item working signals
    logic               accept;
    logic               is_tick;
    logic               run_eff;
    logic               clear_eff;
    logic [15:0]        divider_eff;
    logic               picked;
    logic [16:0]        prescale_inc;
    logic [31:0]        seq_inc;
    logic               hit_start;
    logic               hit_settle;
    logic               hit_step;
    logic               hit_end;
    logic               ref_write;
    logic signed [31:0] ref_value;
    logic               cap_mid;
    logic               run_mid;
    logic               store_it;
    logic               read_ok;
    store_wr_t          store_wr;
    logic [31:0]        store_rd_data;

    assign cfg_ready = 1'b1;
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_tick   = (cmd_item.operation == OP_TICK);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg      <= DIVIDER_RESET;
            settle_count_reg <= {1'b0, SETTLE_RESET};
            step_count_reg   <= {1'b0, SETTLE_RESET} + STEP_OFFSET;
            end_count_reg    <= {1'b0, SETTLE_RESET, 1'b0} + END_OFFSET;
            start_ref_reg    <= '0;
            step_ref_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIVIDER: divider_reg <= cfg_data[15:0];
                REG_SETTLE:
                begin
                    settle_count_reg <= {1'b0, cfg_data[30:0]};
                    step_count_reg   <= {1'b0, cfg_data[30:0]} + STEP_OFFSET;
                    end_count_reg    <= {1'b0, cfg_data[30:0], 1'b0} + END_OFFSET;
                end
                REG_START:   start_ref_reg <= cfg_data;
                REG_STEP:    step_ref_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Tick processing
    always_comb
    begin
        run_eff      = run_reg || cmd_item.start_request;
        clear_eff    = clear_reg || cmd_item.clear_request;
        divider_eff  = (divider_reg == '0) ? 16'd1 : divider_reg;
        picked       = (prescale_reg == '0);
        prescale_inc = {1'b0, prescale_reg} + 17'd1;
        seq_inc      = seq_count_reg + 32'd1;

        // event compares; the end count may exceed 32 bits and never match
        hit_start  = (seq_inc == 32'd1);
        hit_settle = (seq_inc == settle_count_reg);
        hit_step   = (seq_inc == step_count_reg);
        hit_end    = ({1'b0, seq_inc} == end_count_reg);

        prescale_next  = prescale_reg;
        seq_count_next = seq_count_reg;
        run_next       = run_eff;
        clear_next     = clear_eff;
        capture_next   = capture_reg;
        wpos_next      = wpos_reg;
        ref_write      = 1'b0;
        ref_value      = '0;
        cap_mid        = capture_reg;
        run_mid        = run_eff;
        store_it       = 1'b0;

        if (is_tick)
        begin
            prescale_next = (prescale_inc >= {1'b0, divider_eff}) ? '0 : prescale_inc[15:0];

            if (picked)
            begin
                if (run_eff)
                begin
                    seq_count_next = seq_inc;
                    // later event wins: end over step over start
                    if (hit_start)
                    begin
                        ref_write = 1'b1;
                        ref_value = start_ref_reg;
                    end
                    if (hit_step)
                    begin
                        ref_write = 1'b1;
                        ref_value = step_ref_reg;
                    end
                    if (hit_end)
                    begin
                        ref_write = 1'b1;
                        ref_value = '0;
                        run_mid   = 1'b0;
                    end
                    if (hit_settle)
                    begin
                        cap_mid = 1'b1;
                    end
                end

                store_it     = cap_mid && (wpos_reg < COUNT_W'(CAPTURE_DEPTH));
                wpos_next    = store_it ? wpos_reg + COUNT_W'(1) : wpos_reg;
                run_next     = run_mid;
                capture_next = cap_mid;

                // clear only lands once the run is over
                if (clear_eff && !run_mid)
                begin
                    capture_next   = 1'b0;
                    clear_next     = 1'b0;
                    seq_count_next = '0;
                    wpos_next      = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg  <= '0;
            seq_count_reg <= '0;
            run_reg       <= 1'b0;
            clear_reg     <= 1'b0;
            capture_reg   <= 1'b0;
            wpos_reg      <= '0;
        end
        else if (accept)
        begin
            prescale_reg  <= prescale_next;
            seq_count_reg <= seq_count_next;
            run_reg       <= run_next;
            clear_reg     <= clear_next;
            capture_reg   <= capture_next;
            wpos_reg      <= wpos_next;
        end
    end

    // Store access: write on a capturing tick, read on every accepted item
    assign store_wr.en   = accept && store_it;
    assign store_wr.addr = wpos_reg[ADDR_W-1:0];
    assign store_wr.data = {cmd_item.sample_second, cmd_item.sample_first};
    assign read_ok       = (32'(cmd_item.read_index) < CAPTURE_DEPTH);

    srcap_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(cmd_item.read_index)),
        .rd_data (store_rd_data)
    );

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_ref_write_reg <= ref_write;
            rsp_ref_value_reg <= ref_value;
            rsp_recording_reg <= capture_next;
            rsp_active_reg    <= run_next;
            rsp_count_reg     <= wpos_next;
            rsp_read_reg      <= !is_tick && read_ok;
        end
    end

    assign rsp_valid                = rsp_valid_reg;
    assign rsp_item.ref_write       = rsp_ref_write_reg;
    assign rsp_item.ref_value       = rsp_ref_value_reg;
    assign rsp_item.recording       = rsp_recording_reg;
    assign rsp_item.sequence_active = rsp_active_reg;
    assign rsp_item.captured_count  = rsp_count_reg;
    assign rsp_item.read_first      = rsp_read_reg ? store_rd_data[15:0] : '0;
    assign rsp_item.read_second     = rsp_read_reg ? store_rd_data[31:16] : '0;

endmodule
